[src/sph_particle_density_force_accumulator_defines.svh]
// Assertion macros for the SPH accumulator. Empty when SYNTH is defined.
`ifndef SPH_PARTICLE_DENSITY_FORCE_ACCUMULATOR_DEFINES_SVH
`define SPH_PARTICLE_DENSITY_FORCE_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication on clk_i, quiet during reset
`define SPH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication on clk_i, quiet during reset
`define SPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPH_ASSERT_IMP(lbl, ante, cons, msg)
`define SPH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[src/sph_pkg.sv]
package sph_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int QW        = 32;
  localparam int CFG_W     = 31;
  localparam int AXES      = 3;
  localparam int IDX_W     = 2;

  // iterative units: dividend is |a| << FRAC_BITS, radicand is r2 << FRAC_BITS
  localparam int DIV_N    = QW + FRAC_BITS;
  localparam int SQ_N     = DIV_N + (DIV_N % 2);
  localparam int SQ_STEPS = SQ_N / 2;
  localparam int SQ_RW    = SQ_STEPS + 2;
  localparam int CNT_W    = $clog2(DIV_N);

  // register file
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_RADIUS    = 3'd0;
  localparam logic [2:0] REG_MASS      = 3'd1;
  localparam logic [2:0] REG_POLY6     = 3'd2;
  localparam logic [2:0] REG_SPIKY     = 3'd3;
  localparam logic [2:0] REG_STIFFNESS = 3'd4;
  localparam logic [2:0] REG_REST      = 3'd5;
  localparam logic [2:0] REG_VISC      = 3'd6;
  localparam logic [2:0] REG_GRAVITY   = 3'd7;

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_DENS  = 2'd1;
  localparam logic [1:0] REQ_FORCE = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // result kinds
  localparam logic KIND_DENS  = 1'b0;
  localparam logic KIND_ACCEL = 1'b1;

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [2*QW-1:0] W_MAX = {{(QW+1){1'b0}}, {(QW-1){1'b1}}};
  localparam logic signed [2*QW-1:0] W_MIN = {{(QW+1){1'b1}}, {(QW-1){1'b0}}};

  // reset values of the registers
  localparam logic [CFG_W-1:0]     RST_RADIUS    = CFG_W'(98304);
  localparam logic [CFG_W-1:0]     RST_MASS      = CFG_W'(32768);
  localparam logic [CFG_W-1:0]     RST_POLY6     = CFG_W'(2671);
  localparam logic [CFG_W-1:0]     RST_SPIKY     = CFG_W'(82424);
  localparam logic [CFG_W-1:0]     RST_STIFFNESS = CFG_W'(655360);
  localparam logic [CFG_W-1:0]     RST_REST      = CFG_W'(13107);
  localparam logic [CFG_W-1:0]     RST_VISC      = CFG_W'(32768);
  localparam logic signed [QW-1:0] RST_GRAVITY   = -QW'(642253);

  function automatic logic signed [QW-1:0] sat_q(input logic signed [2*QW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > W_MAX) begin
      r = Q_MAX;
    end else if (v < W_MIN) begin
      r = Q_MIN;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  // product shifted down with floor rounding, saturated
  function automatic logic signed [QW-1:0] mul_q(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return sat_q(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [QW-1:0] add_q(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic [QW:0] s;
    logic signed [QW-1:0] r;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      r = s[QW] ? Q_MIN : Q_MAX;
    end else begin
      r = s[QW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [QW-1:0] sub_q(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic [QW:0] s;
    logic signed [QW-1:0] r;
    s = {a[QW-1], a} - {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      r = s[QW] ? Q_MIN : Q_MAX;
    end else begin
      r = s[QW-1:0];
    end
    return r;
  endfunction

endpackage

[src/sph_particle_density_force_accumulator.sv]
// Channel   Direction  Handshake                  Word
// in        input      in_valid_i / in_stall_o    req_type_i .. last_neighbour_i
// out       output     out_valid_o / out_stall_i  result_kind_o .. accel_z_o
// cfg       input      psel/penable/pwrite/pready 8 registers at paddr 4*i
//
// Load items are taken in ST_IDLE; density items outside the radius skip the Poly6
// terms, and the last one adds the self term and the pressure. Force items with a live
// neighbour use four divides on the shared one-bit-per-cycle divider and a square root.
// The last force item adds three divides by the mass.
// in_stall_o is high while an item is in work; a finished word waits in the
// output register. Reset loads default registers and clears the home state.
`include "sph_particle_density_force_accumulator_defines.svh"

module sph_particle_density_force_accumulator import sph_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               req_type_i,
  input  logic signed [QW-1:0]     pos_x_i,
  input  logic signed [QW-1:0]     pos_y_i,
  input  logic signed [QW-1:0]     pos_z_i,
  input  logic signed [QW-1:0]     vel_x_i,
  input  logic signed [QW-1:0]     vel_y_i,
  input  logic signed [QW-1:0]     vel_z_i,
  input  logic [CFG_W-1:0]         density_in_i,
  input  logic signed [QW-1:0]     pressure_in_i,
  input  logic                     last_neighbour_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     result_kind_o,
  output logic [CFG_W-1:0]         density_out_o,
  output logic signed [QW-1:0]     pressure_out_o,
  output logic signed [QW-1:0]     accel_x_o,
  output logic signed [QW-1:0]     accel_y_o,
  output logic signed [QW-1:0]     accel_z_o,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [QW-1:0]            pwdata,
  output logic [QW-1:0]            prdata,
  output logic                     pready
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_DIFF, ST_R2, ST_R2A,
    ST_P_HH, ST_P_CMP, ST_P_DIF, ST_P_SQ, ST_P_CU, ST_P_CO, ST_P_M, ST_P_ACC,
    ST_P_RS, ST_P_PR,
    ST_F_CHK, ST_SQRT, ST_F_VOL, ST_DIV, ST_F_VOLW, ST_F_HR, ST_F_S1, ST_F_S2,
    ST_F_FP1, ST_F_FP2, ST_F_FV1, ST_F_FV2, ST_F_REL, ST_F_DF, ST_F_DVI,
    ST_F_DVW, ST_F_RF, ST_F_TM, ST_F_AC, ST_F_END,
    ST_A_SEL, ST_A_G, ST_A_GA, ST_A_DVI, ST_A_DVW,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL} alu_op_e;

  state_e state_q, ret_q;

  // registers
  logic [CFG_W-1:0]     h_q, m_q, c6_q, sc_q, k_q, rest_q, mu_q;
  logic signed [QW-1:0] grav_q;

  // home particle and accumulators
  logic signed [QW-1:0] hpos_q [AXES];
  logic signed [QW-1:0] hvel_q [AXES];
  logic signed [QW-1:0] fsum_q [AXES];
  logic signed [QW-1:0] hpres_q, dens_q;

  // latched item
  logic [1:0]           type_q;
  logic                 last_q;
  logic signed [QW-1:0] pos_q [AXES];
  logic signed [QW-1:0] vin_q [AXES];
  logic [CFG_W-1:0]     din_q;
  logic signed [QW-1:0] pin_q;

  // working registers
  logic [IDX_W-1:0]     idx_q;
  logic                 self_q;
  logic signed [QW-1:0] d_q [AXES];
  logic signed [QW-1:0] r2_q, ta_q, tb_q, vol_q, pmean_q, fp_q, fv_q, pres_q;
  logic signed [QW-1:0] acc_q [AXES];

  // divider and square root
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_N-1:0]     dq_q;
  logic [CFG_W-1:0]     drem_q, dden_q;
  logic                 dneg_q, dnz_q, dzero_q;
  logic [SQ_N-1:0]      srad_q;
  logic [SQ_RW-1:0]     srem_q;
  logic [SQ_STEPS-1:0]  sroot_q;

  // output register
  logic                 out_valid_q, out_kind_q;
  logic [CFG_W-1:0]     out_dens_q;
  logic signed [QW-1:0] out_pres_q, out_ax_q, out_ay_q, out_az_q;

  logic                 in_acc, cfg_we, last_idx;
  logic signed [QW-1:0] r_ext;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign cfg_we   = psel && penable && pwrite;
  assign last_idx = (idx_q == IDX_W'(AXES - 1));
  assign r_ext    = QW'(sroot_q);

  // shared arithmetic unit: operand select by state
  alu_op_e              alu_op;
  logic signed [QW-1:0] alu_a, alu_b, alu_res;

  always_comb begin
    alu_op = OP_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_q)
      ST_DIFF:  begin alu_op = OP_SUB; alu_a = hpos_q[idx_q]; alu_b = pos_q[idx_q]; end
      ST_R2:    begin alu_op = OP_MUL; alu_a = d_q[idx_q];    alu_b = d_q[idx_q]; end
      ST_R2A:   begin alu_op = OP_ADD; alu_a = r2_q;          alu_b = ta_q; end
      ST_P_HH:  begin alu_op = OP_MUL; alu_a = {1'b0, h_q};   alu_b = {1'b0, h_q}; end
      ST_P_DIF: begin alu_op = OP_SUB; alu_a = ta_q;          alu_b = r2_q; end
      ST_P_SQ:  begin alu_op = OP_MUL; alu_a = ta_q;          alu_b = ta_q; end
      ST_P_CU:  begin alu_op = OP_MUL; alu_a = tb_q;          alu_b = ta_q; end
      ST_P_CO:  begin alu_op = OP_MUL; alu_a = {1'b0, c6_q};  alu_b = tb_q; end
      ST_P_M:   begin alu_op = OP_MUL; alu_a = {1'b0, m_q};   alu_b = tb_q; end
      ST_P_ACC: begin alu_op = OP_ADD; alu_a = dens_q;        alu_b = tb_q; end
      ST_P_RS:  begin alu_op = OP_SUB; alu_a = dens_q;        alu_b = {1'b0, rest_q}; end
      ST_P_PR:  begin alu_op = OP_MUL; alu_a = {1'b0, k_q};   alu_b = ta_q; end
      ST_F_HR:  begin alu_op = OP_SUB; alu_a = {1'b0, h_q};   alu_b = r_ext; end
      ST_F_S1:  begin alu_op = OP_MUL; alu_a = {1'b0, sc_q};  alu_b = ta_q; end
      ST_F_S2:  begin alu_op = OP_MUL; alu_a = tb_q;          alu_b = ta_q; end
      ST_F_FP1: begin alu_op = OP_MUL; alu_a = vol_q;         alu_b = pmean_q; end
      ST_F_FP2: begin alu_op = OP_MUL; alu_a = fp_q;          alu_b = ta_q; end
      ST_F_FV1: begin alu_op = OP_MUL; alu_a = vol_q;         alu_b = {1'b0, mu_q}; end
      ST_F_FV2: begin alu_op = OP_MUL; alu_a = fv_q;          alu_b = tb_q; end
      ST_F_REL: begin alu_op = OP_SUB; alu_a = vin_q[idx_q];  alu_b = hvel_q[idx_q]; end
      ST_F_DF:  begin alu_op = OP_MUL; alu_a = d_q[idx_q];    alu_b = fp_q; end
      ST_F_RF:  begin alu_op = OP_MUL; alu_a = ta_q;          alu_b = fv_q; end
      ST_F_TM:  begin alu_op = OP_SUB; alu_a = ta_q;          alu_b = tb_q; end
      ST_F_AC:  begin alu_op = OP_ADD; alu_a = fsum_q[idx_q]; alu_b = ta_q; end
      ST_A_G:   begin alu_op = OP_MUL; alu_a = grav_q;        alu_b = {1'b0, m_q}; end
      ST_A_GA:  begin alu_op = OP_ADD; alu_a = ta_q;          alu_b = tb_q; end
      default: ;
    endcase
  end

  always_comb begin
    case (alu_op)
      OP_MUL:  alu_res = mul_q(alu_a, alu_b);
      OP_SUB:  alu_res = sub_q(alu_a, alu_b);
      default: alu_res = add_q(alu_a, alu_b);
    endcase
  end

  // divider operands and start
  logic                 div_issue;
  logic signed [QW-1:0] div_a, div_b;
  logic [QW-1:0]        div_mag;

  always_comb begin
    div_issue = 1'b1;
    div_a     = '0;
    div_b     = '0;
    case (state_q)
      ST_F_VOL: begin div_a = {1'b0, m_q}; div_b = {1'b0, din_q}; end
      ST_F_DVI: begin div_a = tb_q;        div_b = r_ext; end
      ST_A_DVI: begin div_a = ta_q;        div_b = {1'b0, m_q}; end
      default:  div_issue = 1'b0;
    endcase
    div_mag = div_a[QW-1] ? (~div_a + 1'b1) : div_a;
  end

  // divider step: one quotient bit per cycle
  logic [CFG_W:0]   dshift;
  logic             dge;
  logic [CFG_W-1:0] drem_d;

  assign dshift = {drem_q, dq_q[DIV_N-1]};
  assign dge    = (dshift >= {1'b0, dden_q});
  assign drem_d = dge ? CFG_W'(dshift - {1'b0, dden_q}) : dshift[CFG_W-1:0];

  // signed, saturated quotient
  localparam logic [DIV_N-1:0] DQ_LIM = DIV_N'(1) << (QW - 1);
  logic [DIV_N-1:0]     dq_neg;
  logic signed [QW-1:0] div_res;

  always_comb begin
    dq_neg = ~dq_q + 1'b1;
    if (dzero_q) begin
      div_res = dneg_q ? Q_MIN : (dnz_q ? Q_MAX : '0);
    end else if (dneg_q) begin
      div_res = (dq_q > DQ_LIM) ? Q_MIN : dq_neg[QW-1:0];
    end else begin
      div_res = (dq_q >= DQ_LIM) ? Q_MAX : dq_q[QW-1:0];
    end
  end

  // square root step: one root bit per cycle
  logic [SQ_RW+1:0] rem_sh, trial;
  logic             sge;

  assign rem_sh = {srem_q, srad_q[SQ_N-1 -: 2]};
  assign trial  = {2'b00, sroot_q, 2'b01};
  assign sge    = (rem_sh >= trial);

  // mean pressure, truncated toward zero
  logic [QW:0] psum, pround;
  assign psum   = {hpres_q[QW-1], hpres_q} + {pin_q[QW-1], pin_q};
  assign pround = psum + (QW+1)'(psum[QW]);

  // sequencer, registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      out_valid_q <= 1'b0;
      h_q         <= RST_RADIUS;
      m_q         <= RST_MASS;
      c6_q        <= RST_POLY6;
      sc_q        <= RST_SPIKY;
      k_q         <= RST_STIFFNESS;
      rest_q      <= RST_REST;
      mu_q        <= RST_VISC;
      grav_q      <= RST_GRAVITY;
      hpres_q     <= '0;
      dens_q      <= '0;
      for (int i = 0; i < AXES; i++) begin
        hpos_q[i] <= '0;
        hvel_q[i] <= '0;
        fsum_q[i] <= '0;
        pos_q[i]  <= '0;
        vin_q[i]  <= '0;
        d_q[i]    <= '0;
        acc_q[i]  <= '0;
      end
      type_q     <= REQ_LOAD;
      last_q     <= 1'b0;
      din_q      <= '0;
      pin_q      <= '0;
      idx_q      <= '0;
      self_q     <= 1'b0;
      r2_q       <= '0;
      ta_q       <= '0;
      tb_q       <= '0;
      vol_q      <= '0;
      pmean_q    <= '0;
      fp_q       <= '0;
      fv_q       <= '0;
      pres_q     <= '0;
      cnt_q      <= '0;
      dq_q       <= '0;
      drem_q     <= '0;
      dden_q     <= '0;
      dneg_q     <= 1'b0;
      dnz_q      <= 1'b0;
      dzero_q    <= 1'b0;
      srad_q     <= '0;
      srem_q     <= '0;
      sroot_q    <= '0;
      out_kind_q <= KIND_DENS;
      out_dens_q <= '0;
      out_pres_q <= '0;
      out_ax_q   <= '0;
      out_ay_q   <= '0;
      out_az_q   <= '0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (paddr[4:2])
          REG_RADIUS:    h_q    <= pwdata[CFG_W-1:0];
          REG_MASS:      m_q    <= pwdata[CFG_W-1:0];
          REG_POLY6:     c6_q   <= pwdata[CFG_W-1:0];
          REG_SPIKY:     sc_q   <= pwdata[CFG_W-1:0];
          REG_STIFFNESS: k_q    <= pwdata[CFG_W-1:0];
          REG_REST:      rest_q <= pwdata[CFG_W-1:0];
          REG_VISC:      mu_q   <= pwdata[CFG_W-1:0];
          REG_GRAVITY:   grav_q <= pwdata;
          default: ;
        endcase
      end

      // output word taken; ST_OUT reloads it itself
      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end

      // divider start
      if (div_issue) begin
        dq_q    <= {div_mag, {FRAC_BITS{1'b0}}};
        drem_q  <= '0;
        dden_q  <= div_b[CFG_W-1:0];
        dneg_q  <= div_a[QW-1];
        dnz_q   <= |div_a;
        dzero_q <= (div_b == '0);
        cnt_q   <= CNT_W'(DIV_N - 1);
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (req_type_i)
              REQ_LOAD: begin
                hpos_q[0] <= pos_x_i;
                hpos_q[1] <= pos_y_i;
                hpos_q[2] <= pos_z_i;
                hvel_q[0] <= vel_x_i;
                hvel_q[1] <= vel_y_i;
                hvel_q[2] <= vel_z_i;
                hpres_q   <= pressure_in_i;
                dens_q    <= '0;
                for (int i = 0; i < AXES; i++) begin
                  fsum_q[i] <= '0;
                end
              end
              REQ_DENS, REQ_FORCE: begin
                type_q   <= req_type_i;
                last_q   <= last_neighbour_i;
                pos_q[0] <= pos_x_i;
                pos_q[1] <= pos_y_i;
                pos_q[2] <= pos_z_i;
                vin_q[0] <= vel_x_i;
                vin_q[1] <= vel_y_i;
                vin_q[2] <= vel_z_i;
                din_q    <= density_in_i;
                pin_q    <= pressure_in_i;
                idx_q    <= '0;
                self_q   <= 1'b0;
                r2_q     <= '0;
                state_q  <= ST_DIFF;
              end
              default: ;
            endcase
          end
        end

        // distance vector and squared distance
        ST_DIFF: begin
          d_q[idx_q] <= alu_res;
          if (last_idx) begin
            idx_q   <= '0;
            state_q <= ST_R2;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_R2: begin
          ta_q    <= alu_res;
          state_q <= ST_R2A;
        end
        ST_R2A: begin
          r2_q <= alu_res;
          if (last_idx) begin
            idx_q   <= '0;
            state_q <= (type_q == REQ_DENS) ? ST_P_HH : ST_F_CHK;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_R2;
          end
        end

        // Poly6 density term
        ST_P_HH: begin
          ta_q    <= alu_res;
          state_q <= ST_P_CMP;
        end
        ST_P_CMP: begin
          if (r2_q > ta_q) begin
            tb_q    <= '0;
            state_q <= ST_P_M;
          end else begin
            state_q <= ST_P_DIF;
          end
        end
        ST_P_DIF: begin
          ta_q    <= alu_res;
          state_q <= ST_P_SQ;
        end
        ST_P_SQ: begin
          tb_q    <= alu_res;
          state_q <= ST_P_CU;
        end
        ST_P_CU: begin
          tb_q    <= alu_res;
          state_q <= ST_P_CO;
        end
        ST_P_CO: begin
          tb_q    <= alu_res;
          state_q <= ST_P_M;
        end
        ST_P_M: begin
          tb_q    <= alu_res;
          state_q <= ST_P_ACC;
        end
        ST_P_ACC: begin
          dens_q <= alu_res;
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (!self_q) begin
            // self term: same kernel at zero distance
            self_q  <= 1'b1;
            r2_q    <= '0;
            state_q <= ST_P_HH;
          end else begin
            state_q <= ST_P_RS;
          end
        end
        ST_P_RS: begin
          ta_q    <= alu_res;
          state_q <= ST_P_PR;
        end
        ST_P_PR: begin
          pres_q  <= alu_res;
          state_q <= ST_OUT;
        end

        // force term setup
        ST_F_CHK: begin
          if (r2_q == '0 || din_q == '0) begin
            state_q <= ST_F_END;
          end else begin
            srad_q  <= SQ_N'({r2_q, {FRAC_BITS{1'b0}}});
            srem_q  <= '0;
            sroot_q <= '0;
            cnt_q   <= CNT_W'(SQ_STEPS - 1);
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          srem_q  <= sge ? SQ_RW'(rem_sh - trial) : SQ_RW'(rem_sh);
          sroot_q <= {sroot_q[SQ_STEPS-2:0], sge};
          srad_q  <= {srad_q[SQ_N-3:0], 2'b00};
          cnt_q   <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_F_VOL;
          end
        end
        ST_F_VOL: begin
          pmean_q <= pround[QW:1];
          ret_q   <= ST_F_VOLW;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          drem_q <= drem_d;
          dq_q   <= {dq_q[DIV_N-2:0], dge};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ret_q;
          end
        end
        ST_F_VOLW: begin
          vol_q   <= div_res;
          state_q <= ST_F_HR;
        end
        ST_F_HR: begin
          if (r_ext > $signed({1'b0, h_q})) begin
            ta_q    <= '0;
            tb_q    <= '0;
            state_q <= ST_F_FP1;
          end else begin
            ta_q    <= alu_res;
            state_q <= ST_F_S1;
          end
        end
        ST_F_S1: begin
          tb_q    <= alu_res;
          state_q <= ST_F_S2;
        end
        ST_F_S2: begin
          // Spiky gradient is negative; product is never negative here
          ta_q    <= -alu_res;
          state_q <= ST_F_FP1;
        end
        ST_F_FP1: begin
          fp_q    <= alu_res;
          state_q <= ST_F_FP2;
        end
        ST_F_FP2: begin
          fp_q    <= alu_res;
          state_q <= ST_F_FV1;
        end
        ST_F_FV1: begin
          fv_q    <= alu_res;
          state_q <= ST_F_FV2;
        end
        ST_F_FV2: begin
          fv_q    <= alu_res;
          idx_q   <= '0;
          state_q <= ST_F_REL;
        end

        // per-axis force update
        ST_F_REL: begin
          ta_q    <= alu_res;
          state_q <= ST_F_DF;
        end
        ST_F_DF: begin
          tb_q    <= alu_res;
          state_q <= ST_F_DVI;
        end
        ST_F_DVI: begin
          ret_q   <= ST_F_DVW;
          state_q <= ST_DIV;
        end
        ST_F_DVW: begin
          tb_q    <= div_res;
          state_q <= ST_F_RF;
        end
        ST_F_RF: begin
          ta_q    <= alu_res;
          state_q <= ST_F_TM;
        end
        ST_F_TM: begin
          ta_q    <= alu_res;
          state_q <= ST_F_AC;
        end
        ST_F_AC: begin
          fsum_q[idx_q] <= alu_res;
          if (last_idx) begin
            state_q <= ST_F_END;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_F_REL;
          end
        end
        ST_F_END: begin
          idx_q   <= '0;
          state_q <= last_q ? ST_A_SEL : ST_IDLE;
        end

        // acceleration: force / m per axis, with gravity * m added to the y force first
        ST_A_SEL: begin
          ta_q    <= fsum_q[idx_q];
          state_q <= (idx_q == 2'd1) ? ST_A_G : ST_A_DVI;
        end
        ST_A_G: begin
          tb_q    <= alu_res;
          state_q <= ST_A_GA;
        end
        ST_A_GA: begin
          ta_q    <= alu_res;
          state_q <= ST_A_DVI;
        end
        ST_A_DVI: begin
          ret_q   <= ST_A_DVW;
          state_q <= ST_DIV;
        end
        ST_A_DVW: begin
          acc_q[idx_q] <= div_res;
          if (last_idx) begin
            state_q <= ST_OUT;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_A_SEL;
          end
        end

        // hand the word to the output register
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            if (type_q == REQ_DENS) begin
              out_kind_q <= KIND_DENS;
              out_dens_q <= dens_q[CFG_W-1:0];
              out_pres_q <= pres_q;
              out_ax_q   <= '0;
              out_ay_q   <= '0;
              out_az_q   <= '0;
            end else begin
              out_kind_q <= KIND_ACCEL;
              out_dens_q <= '0;
              out_pres_q <= '0;
              out_ax_q   <= acc_q[0];
              out_ay_q   <= acc_q[1];
              out_az_q   <= acc_q[2];
            end
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // register read
  always_comb begin
    case (paddr[4:2])
      REG_RADIUS:    prdata = {1'b0, h_q};
      REG_MASS:      prdata = {1'b0, m_q};
      REG_POLY6:     prdata = {1'b0, c6_q};
      REG_SPIKY:     prdata = {1'b0, sc_q};
      REG_STIFFNESS: prdata = {1'b0, k_q};
      REG_REST:      prdata = {1'b0, rest_q};
      REG_VISC:      prdata = {1'b0, mu_q};
      default:       prdata = grav_q;
    endcase
  end

  assign pready         = 1'b1;
  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_kind_q;
  assign density_out_o  = out_dens_q;
  assign pressure_out_o = out_pres_q;
  assign accel_x_o      = out_ax_q;
  assign accel_y_o      = out_ay_q;
  assign accel_z_o      = out_az_q;

  // checks
  `SPH_ASSERT_IMP(a_dens_word_no_accel, out_valid_o && (result_kind_o == KIND_DENS), accel_x_o == '0 && accel_y_o == '0 && accel_z_o == '0, "density word carries acceleration")
  `SPH_ASSERT_IMP(a_accel_word_no_dens, out_valid_o && (result_kind_o == KIND_ACCEL), density_out_o == '0 && pressure_out_o == '0, "acceleration word carries density")
  `SPH_ASSERT_NEXT(a_unused_req_idle, in_valid_i && !in_stall_o && (req_type_i == REQ_NONE), state_q == ST_IDLE, "unused request started work")
  `SPH_ASSERT_NEXT(a_load_clears, in_valid_i && !in_stall_o && (req_type_i == REQ_LOAD), dens_q == '0 && fsum_q[0] == '0 && fsum_q[2] == '0, "load did not clear accumulators")

endmodule
